// ----- src/amd_pkg.sv -----
// ----------------------------------------------------------------------------
// amd_pkg
// shared types, codes and widths of the adjacency matrix depth-first walker
// ----------------------------------------------------------------------------
package amd_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int KIND_W    = 2;
  localparam int LABEL_W   = 8;
  localparam int OUT_IDX_W = 4;
  localparam int STATUS_W  = 2;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_ADD_VERTEX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_EDGE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RUN        = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_E1,
    S_E2,
    S_E3,
    S_LBL,
    S_PICK,
    S_TOP,
    S_ROW,
    S_DONE,
    S_ERR
  } st_t;

endpackage

// ----- src/adjacency_matrix_dfs_top.sv -----
// add vertex stays in idle; a full table, or a search on an empty graph, gives an error result
// add edge: label scan through the label ram, then two adjacency row updates; an unknown
//   label gives an error result instead
// search: each reached vertex is visited (S_PICK, S_LBL) and later popped (S_PICK, S_TOP, S_ROW)
// one item at a time, output stalls hold it up; next item taken once the last result is registered
// reset empties the graph at once (vertex count, stack pointer, visited marks)
// ----------------------------------------------------------------------------
// adjacency_matrix_dfs_top
// loads an undirected graph into an adjacency matrix and walks it depth first
// from vertex 0, emitting each visited vertex as one result item, each error as an error item
// ----------------------------------------------------------------------------
module adjacency_matrix_dfs_top #(
  parameter int MAX_VERTICES = amd_pkg::MAX_VERTICES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [amd_pkg::KIND_W-1:0]     in_kind,
  input  logic [amd_pkg::LABEL_W-1:0]    in_label_a,
  input  logic [amd_pkg::LABEL_W-1:0]    in_label_b,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [amd_pkg::OUT_IDX_W-1:0]  out_vertex_index,
  output logic [amd_pkg::LABEL_W-1:0]    out_vertex_label,
  output logic [amd_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_last
);

  import amd_pkg::*;

  localparam int IDXW = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);

  // sequencer state
  st_t state_r, state_nxt;

  // graph bookkeeping
  logic [CNTW-1:0]         count_r, count_nxt;
  logic [CNTW-1:0]         sp_r, sp_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;

  // label scan for edge items
  logic [LABEL_W-1:0] la_r, la_nxt;
  logic [LABEL_W-1:0] lb_r, lb_nxt;
  logic [CNTW-1:0]    scan_r, scan_nxt;
  logic               cmp_v_r, cmp_v_nxt;
  logic [IDXW-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic               sf_r, sf_nxt;
  logic               ef_r, ef_nxt;
  logic [IDXW-1:0]    s_r, s_nxt;
  logic [IDXW-1:0]    e_r, e_nxt;

  // walk datapath
  logic [IDXW-1:0]    top_r, top_nxt;
  logic [IDXW-1:0]    pend_idx_r, pend_idx_nxt;
  logic [LABEL_W-1:0] pend_lbl_r, pend_lbl_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [LABEL_W-1:0]   out_lbl_r, out_lbl_nxt;
  logic [STATUS_W-1:0]  out_st_r, out_st_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;
  logic                 out_free;

  // ram ports
  logic                    lbl_we;
  logic [IDXW-1:0]         lbl_waddr, lbl_raddr;
  logic [LABEL_W-1:0]      lbl_wdata, lbl_rdata;
  logic                    adj_we;
  logic [IDXW-1:0]         adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    stk_we;
  logic [IDXW-1:0]         stk_waddr, stk_raddr;
  logic [IDXW-1:0]         stk_wdata, stk_rdata;

  // misc
  logic                    in_acc;
  logic                    full;
  logic                    scan_done;
  logic [MAX_VERTICES-1:0] cand;
  logic [IDXW-1:0]         nx;
  logic                    nx_any;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign full      = (count_r == CNTW'(MAX_VERTICES));
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_done = (scan_r == count_r) && !cmp_v_r;

  // unvisited neighbors of the stack top
  assign cand = adj_rdata & ~visited_r;

  amd_ffs #(.WIDTH(MAX_VERTICES)) u_ffs (
    .vec (cand),
    .idx (nx),
    .any (nx_any)
  );

  // label table
  amd_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VERTICES)) u_lbl_ram (
    .clk   (clk),
    .we    (lbl_we),
    .waddr (lbl_waddr),
    .wdata (lbl_wdata),
    .raddr (lbl_raddr),
    .rdata (lbl_rdata)
  );

  // adjacency matrix, one row per vertex
  amd_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  // walk stack
  amd_ram #(.WIDTH(IDXW), .DEPTH(MAX_VERTICES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_ADD_VERTEX: state_nxt = full ? S_ERR : S_IDLE;
            KIND_ADD_EDGE:   state_nxt = S_FIND;
            KIND_RUN:        state_nxt = (count_r == '0) ? S_ERR : S_LBL;
            default:         state_nxt = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (scan_done) begin
          state_nxt = (sf_r && ef_r) ? S_E1 : S_ERR;
        end
      end
      S_E1: state_nxt = S_E2;
      S_E2: state_nxt = S_E3;
      S_E3: state_nxt = S_IDLE;
      S_LBL: state_nxt = S_PICK;
      S_PICK: begin
        if (nx_any) begin
          // previous visit must leave through the output register first
          if (out_free) begin
            state_nxt = S_LBL;
          end
        end else begin
          state_nxt = (sp_r == CNTW'(1)) ? S_DONE : S_TOP;
        end
      end
      S_TOP: state_nxt = S_ROW;
      S_ROW: state_nxt = S_PICK;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    count_nxt    = count_r;
    sp_nxt       = sp_r;
    visited_nxt  = visited_r;
    la_nxt       = la_r;
    lb_nxt       = lb_r;
    scan_nxt     = scan_r;
    cmp_v_nxt    = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    sf_nxt       = sf_r;
    ef_nxt       = ef_r;
    s_nxt        = s_r;
    e_nxt        = e_r;
    top_nxt      = top_r;
    pend_idx_nxt = pend_idx_r;
    pend_lbl_nxt = pend_lbl_r;
    err_nxt      = err_r;

    out_load     = 1'b0;
    out_idx_nxt  = out_idx_r;
    out_lbl_nxt  = out_lbl_r;
    out_st_nxt   = out_st_r;
    out_last_nxt = out_last_r;

    lbl_we    = 1'b0;
    lbl_waddr = count_r[IDXW-1:0];
    lbl_wdata = in_label_a;
    lbl_raddr = '0;
    adj_we    = 1'b0;
    adj_waddr = count_r[IDXW-1:0];
    adj_wdata = '0;
    adj_raddr = top_r;
    stk_we    = 1'b0;
    stk_waddr = sp_r[IDXW-1:0];
    stk_wdata = nx;
    stk_raddr = IDXW'(sp_r - CNTW'(1));

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_ADD_VERTEX: begin
              if (full) begin
                err_nxt = ST_FULL;
              end else begin
                // new vertex starts with an empty row
                lbl_we    = 1'b1;
                adj_we    = 1'b1;
                count_nxt = count_r + CNTW'(1);
              end
            end
            KIND_ADD_EDGE: begin
              la_nxt   = in_label_a;
              lb_nxt   = in_label_b;
              scan_nxt = '0;
              sf_nxt   = 1'b0;
              ef_nxt   = 1'b0;
            end
            KIND_RUN: begin
              if (count_r == '0) begin
                err_nxt = ST_EMPTY;
              end else begin
                // visit vertex 0 and push it; its label is read now
                visited_nxt  = MAX_VERTICES'(1);
                stk_we       = 1'b1;
                stk_waddr    = '0;
                stk_wdata    = '0;
                sp_nxt       = CNTW'(1);
                pend_idx_nxt = '0;
                top_nxt      = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIND: begin
        lbl_raddr = scan_r[IDXW-1:0];
        if (scan_r < count_r) begin
          scan_nxt    = scan_r + CNTW'(1);
          cmp_v_nxt   = 1'b1;
          cmp_idx_nxt = scan_r[IDXW-1:0];
        end
        // later matches override earlier ones
        if (cmp_v_r) begin
          if (lbl_rdata == la_r) begin
            sf_nxt = 1'b1;
            s_nxt  = cmp_idx_r;
          end
          if (lbl_rdata == lb_r) begin
            ef_nxt = 1'b1;
            e_nxt  = cmp_idx_r;
          end
        end
        if (scan_done && !(sf_r && ef_r)) begin
          err_nxt = ST_UNKNOWN;
        end
      end
      S_E1: begin
        adj_raddr = s_r;
      end
      S_E2: begin
        adj_we    = 1'b1;
        adj_waddr = s_r;
        adj_wdata = adj_rdata | (MAX_VERTICES'(1) << e_r);
        adj_raddr = e_r;
      end
      S_E3: begin
        adj_we    = 1'b1;
        adj_waddr = e_r;
        adj_wdata = adj_rdata | (MAX_VERTICES'(1) << s_r);
      end
      S_LBL: begin
        pend_lbl_nxt = lbl_rdata;
        adj_raddr    = top_r;
      end
      S_PICK: begin
        adj_raddr = top_r;
        lbl_raddr = nx;
        if (nx_any) begin
          if (out_free) begin
            // release the previous visit, then visit and push nx
            out_load     = 1'b1;
            out_idx_nxt  = OUT_IDX_W'(pend_idx_r);
            out_lbl_nxt  = pend_lbl_r;
            out_st_nxt   = ST_OK;
            out_last_nxt = 1'b0;
            visited_nxt  = visited_r | (MAX_VERTICES'(1) << nx);
            stk_we       = 1'b1;
            sp_nxt       = sp_r + CNTW'(1);
            pend_idx_nxt = nx;
            top_nxt      = nx;
          end
        end else begin
          sp_nxt = sp_r - CNTW'(1);
        end
      end
      S_TOP: ;
      S_ROW: begin
        adj_raddr = stk_rdata;
        top_nxt   = stk_rdata;
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_idx_nxt  = OUT_IDX_W'(pend_idx_r);
          out_lbl_nxt  = pend_lbl_r;
          out_st_nxt   = ST_OK;
          out_last_nxt = 1'b1;
          visited_nxt  = '0;
        end
      end
      S_ERR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_idx_nxt  = '0;
          out_lbl_nxt  = '0;
          out_st_nxt   = err_r;
          out_last_nxt = 1'b1;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sp_r        <= '0;
      visited_r   <= '0;
      cmp_v_r     <= 1'b0;
      sf_r        <= 1'b0;
      ef_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sp_r        <= sp_nxt;
      visited_r   <= visited_nxt;
      cmp_v_r     <= cmp_v_nxt;
      sf_r        <= sf_nxt;
      ef_r        <= ef_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    la_r       <= la_nxt;
    lb_r       <= lb_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    top_r      <= top_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_lbl_r <= pend_lbl_nxt;
    err_r      <= err_nxt;
    out_idx_r  <= out_idx_nxt;
    out_lbl_r  <= out_lbl_nxt;
    out_st_r   <= out_st_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_index = out_idx_r;
  assign out_vertex_label = out_lbl_r;
  assign out_status       = out_st_r;
  assign out_last         = out_last_r;

endmodule

// ----- src/amd_ram.sv -----
// ----------------------------------------------------------------------------
// amd_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module amd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/amd_ffs.sv -----
// ----------------------------------------------------------------------------
// amd_ffs
// lowest set bit finder: isolates the bit with one add, then encodes it
// ----------------------------------------------------------------------------
module amd_ffs #(
  parameter int WIDTH = 16
) (
  input  logic [WIDTH-1:0]         vec,
  output logic [$clog2(WIDTH)-1:0] idx,
  output logic                     any
);

  localparam int IW = $clog2(WIDTH);

  logic [WIDTH-1:0] low;

  // two's complement trick leaves only the lowest set bit
  assign low = vec & (~vec + WIDTH'(1));
  assign any = |vec;

  always_comb begin
    idx = '0;
    for (int i = 0; i < WIDTH; i++) begin
      if (low[i]) begin
        idx = idx | IW'(i);
      end
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the adjacency matrix depth-first walker: graph items
// go in through the input channel under random idling, a behavioral copy of
// the graph predicts every visit and error result, and a monitor compares
// each result item against the oldest prediction
// ----------------------------------------------------------------------------
module testbench;
  import amd_pkg::*;

  localparam int NV          = MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 100;

  // the one kind the block ignores
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] vertex_index;
    logic [LABEL_W-1:0]   vertex_label;
    logic [STATUS_W-1:0]  status;
    logic                 last;
  } visit_t;

  // clock, reset and block ports; the ones the bench drives are known from time zero
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind = '0;
  logic [LABEL_W-1:0]    in_label_a = '0;
  logic [LABEL_W-1:0]    in_label_b = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OUT_IDX_W-1:0]  out_vertex_index;
  logic [LABEL_W-1:0]    out_vertex_label;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_last;

  // shadow copy of the graph kept by the predictor
  logic [NV-1:0]         graph_adj [0:NV-1];
  logic [LABEL_W-1:0]    graph_label [0:NV-1];
  int                    graph_count = 0;

  // predicted result items, oldest first
  visit_t                expected_visits [$];
  visit_t                want;

  int                    fail_count = 0;
  int                    cycle_count = 0;
  int                    send_idle_pct = 0;
  int                    recv_idle_pct = 0;

  adjacency_matrix_dfs_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_label_a       (in_label_a),
    .in_label_b       (in_label_b),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_vertex_index (out_vertex_index),
    .out_vertex_label (out_vertex_label),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  always #10 clk = ~clk;

  // run-length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("adjacency_matrix_dfs_top verification failed");
      $finish;
    end
  end

  // receiver side: random stall, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // result monitor: each accepted result item against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_visits.size() == 0) begin
        $error("unexpected result item: index %0d label %0d status %0d last %0d",
               out_vertex_index, out_vertex_label, out_status, out_last);
        fail_count++;
      end else begin
        want = expected_visits.pop_front();
        if (out_vertex_index !== want.vertex_index) begin
          $error("vertex_index expected %0d actual %0d", want.vertex_index, out_vertex_index);
          fail_count++;
        end
        if (out_vertex_label !== want.vertex_label) begin
          $error("vertex_label expected %0d actual %0d", want.vertex_label, out_vertex_label);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last expected %0d actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // highest-numbered vertex carrying this label, -1 when none does
  function automatic int find_vertex(input logic [LABEL_W-1:0] lbl);
    int found;
    found = -1;
    for (int i = 0; i < graph_count; i++)
      if (graph_label[i] == lbl) found = i;
    return found;
  endfunction

  task automatic push_error(input logic [STATUS_W-1:0] code);
    expected_visits.push_back('{vertex_index: '0, vertex_label: '0, status: code, last: 1'b1});
  endtask

  // update the shadow graph with one item and predict what it emits
  task automatic apply_graph_item(input logic [KIND_W-1:0] kind,
                                  input logic [LABEL_W-1:0] la,
                                  input logic [LABEL_W-1:0] lb);
    int ia;
    int ib;
    int top;
    int nx;
    int sp;
    logic [NV-1:0] seen;
    logic [OUT_IDX_W-1:0] path [0:NV-1];
    visit_t held;
    case (kind)
      KIND_ADD_VERTEX: begin
        if (graph_count >= NV) begin
          push_error(ST_FULL);
        end else begin
          graph_label[graph_count] = la;
          graph_adj[graph_count] = '0;
          graph_count++;
        end
      end
      KIND_ADD_EDGE: begin
        ia = find_vertex(la);
        ib = find_vertex(lb);
        if (ia < 0 || ib < 0) begin
          push_error(ST_UNKNOWN);
        end else begin
          graph_adj[ia][ib] = 1'b1;
          graph_adj[ib][ia] = 1'b1;
        end
      end
      KIND_RUN: begin
        if (graph_count == 0) begin
          push_error(ST_EMPTY);
        end else begin
          // hold each visit back one step so the final one can carry last
          seen = NV'(1);
          held = '{vertex_index: '0, vertex_label: graph_label[0], status: ST_OK, last: 1'b0};
          path[0] = '0;
          sp = 1;
          while (sp > 0) begin
            top = int'(path[sp-1]);
            nx = -1;
            for (int i = 0; i < graph_count; i++)
              if (nx < 0 && graph_adj[top][i] && !seen[i]) nx = i;
            if (nx < 0) begin
              sp--;
            end else begin
              seen[nx] = 1'b1;
              expected_visits.push_back(held);
              held = '{vertex_index: nx[OUT_IDX_W-1:0], vertex_label: graph_label[nx],
                       status: ST_OK, last: 1'b0};
              path[sp] = nx[OUT_IDX_W-1:0];
              sp++;
            end
          end
          held.last = 1'b1;
          expected_visits.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  // drive one item, hold it through stalls, predict once it is taken
  task automatic send_graph_item(input logic [KIND_W-1:0] kind,
                                 input logic [LABEL_W-1:0] la,
                                 input logic [LABEL_W-1:0] lb);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_kind    <= kind;
    in_label_a <= la;
    in_label_b <= lb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_graph_item(kind, la, lb);
  endtask

  // sender holds off until every predicted result item has come back
  task automatic drain_results;
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_visits.size() != 0);
  endtask

  // mostly labels already in the table, now and then a random one
  function automatic logic [LABEL_W-1:0] pick_label();
    if (graph_count > 0 && $urandom_range(0, 9) != 0)
      return graph_label[$urandom_range(0, graph_count - 1)];
    return LABEL_W'($urandom_range(0, 255));
  endfunction

  // search and edge on an empty graph, plus the ignored kind
  task automatic test_empty_graph;
    send_graph_item(KIND_RUN, 8'h00, 8'hFF);
    send_graph_item(KIND_ADD_EDGE, 8'h00, 8'h00);
    send_graph_item(KIND_UNUSED, 8'hFF, 8'hFF);
  endtask

  // small graph with duplicate labels, a self loop, unknown ends and an
  // unreachable vertex
  task automatic test_small_graph;
    send_graph_item(KIND_ADD_VERTEX, 8'h00, 8'hFF);
    send_graph_item(KIND_ADD_VERTEX, 8'hFF, 8'h00);
    send_graph_item(KIND_ADD_VERTEX, 8'hA5, 8'h5A);
    send_graph_item(KIND_ADD_VERTEX, 8'h5A, 8'hA5);
    send_graph_item(KIND_ADD_VERTEX, 8'hFF, 8'h00);   // duplicate, later copy wins
    send_graph_item(KIND_ADD_EDGE, 8'h00, 8'hFF);
    send_graph_item(KIND_ADD_EDGE, 8'hA5, 8'h5A);
    send_graph_item(KIND_ADD_EDGE, 8'h5A, 8'h5A);     // self loop
    send_graph_item(KIND_ADD_EDGE, 8'hFF, 8'hA5);
    send_graph_item(KIND_ADD_EDGE, 8'h00, 8'h77);     // unknown second end
    send_graph_item(KIND_ADD_EDGE, 8'h77, 8'h00);     // unknown first end
    send_graph_item(KIND_RUN, 8'hFF, 8'hFF);
    send_graph_item(KIND_UNUSED, 8'h00, 8'h00);
    send_graph_item(KIND_ADD_EDGE, 8'hA5, 8'h00);
    send_graph_item(KIND_RUN, 8'h00, 8'h00);
  endtask

  // random graph traffic; the table fills up part way through the run
  task automatic test_random_traffic(input int count);
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 1))
          send_graph_item(KIND_ADD_VERTEX, LABEL_W'($urandom_range(0, 3)),
                          LABEL_W'($urandom));
        else
          send_graph_item(KIND_ADD_VERTEX, LABEL_W'($urandom), LABEL_W'($urandom));
        sent++;
      end else if (pick < 55) begin
        send_graph_item(KIND_ADD_EDGE, pick_label(), pick_label());
        sent++;
      end else if (pick < 90) begin
        send_graph_item(KIND_RUN, LABEL_W'($urandom), LABEL_W'($urandom));
        sent++;
      end else if (pick < 95) begin
        send_graph_item(KIND_ADD_EDGE, LABEL_W'($urandom), LABEL_W'($urandom));
        sent++;
      end else begin
        // ignored kind, not counted
        send_graph_item(KIND_UNUSED, LABEL_W'($urandom), LABEL_W'($urandom));
      end
    end
  endtask

  // fill the table, overflow it, add an edge, then walk the full graph
  task automatic test_table_full;
    while (graph_count < NV)
      send_graph_item(KIND_ADD_VERTEX, LABEL_W'($urandom), LABEL_W'($urandom));
    send_graph_item(KIND_ADD_VERTEX, 8'hFF, 8'hFF);
    send_graph_item(KIND_ADD_VERTEX, 8'h00, 8'h00);
    send_graph_item(KIND_ADD_EDGE, pick_label(), pick_label());
    send_graph_item(KIND_RUN, 8'h00, 8'h00);
  endtask

  initial begin
    for (int i = 0; i < NV; i++) begin
      graph_adj[i]   = '0;
      graph_label[i] = '0;
    end
    // hold the synchronous reset, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // phase one: sender idles lightly, receiver stalls hard
    send_idle_pct = 37;
    recv_idle_pct = 83;
    test_empty_graph();
    test_small_graph();
    test_random_traffic(110);
    drain_results();

    // phase two: roles swapped
    send_idle_pct = 83;
    recv_idle_pct = 37;
    test_random_traffic(110);
    drain_results();

    // phase three: back to back, no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(105);
    test_table_full();

    // let everything land, then give the block time to settle
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_visits.size() == 0) begin
      $display("adjacency_matrix_dfs_top verification clean");
    end else begin
      $display("adjacency_matrix_dfs_top verification failed");
    end
    $finish;
  end

endmodule
